// File: hdl/bed_pkg.sv
// types, character codes and helper functions for the backslash escape decoder
`timescale 1ns / 1ps

package bed_pkg;

  // most result words one input word can cause
  localparam int unsigned MaxResults = 3;
  localparam int unsigned CntW       = 2;

  // decoder modes
  typedef enum logic [4:0] {
    MODE_NORMAL    = 5'b00001,
    MODE_BACKSLASH = 5'b00010,
    MODE_OCTAL     = 5'b00100,
    MODE_HEX       = 5'b01000,
    MODE_STOPPED   = 5'b10000
  } mode_t;

  // character codes
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_LOW_A = 8'h61;
  localparam logic [7:0] CH_LOW_B = 8'h62;
  localparam logic [7:0] CH_LOW_C = 8'h63;
  localparam logic [7:0] CH_LOW_E = 8'h65;
  localparam logic [7:0] CH_LOW_F = 8'h66;
  localparam logic [7:0] CH_LOW_N = 8'h6E;
  localparam logic [7:0] CH_LOW_R = 8'h72;
  localparam logic [7:0] CH_LOW_T = 8'h74;
  localparam logic [7:0] CH_LOW_V = 8'h76;
  localparam logic [7:0] CH_LOW_X = 8'h78;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_BEL   = 8'h07;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_HT    = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_NUL   = 8'h00;

  // digit limits of the numeric escapes
  localparam logic [CntW-1:0] OctDigits = 2'd3;
  localparam logic [CntW-1:0] HexDigits = 2'd2;

  // one result word
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       stop_seen;
  } res_t;

  // results of one input word
  typedef struct packed {
    res_t [MaxResults-1:0] item;
    logic [CntW-1:0]       n;
  } res_list_t;

  // hex digit lookup: valid flag and value
  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_dig_t;

  // append a result, dropping anything past the limit
  function automatic res_list_t emit(res_list_t l, logic [7:0] b, logic v, logic s);
    res_list_t r;
    r = l;
    if (l.n < CntW'(MaxResults)) begin
      r.item[l.n] = '{out_byte: b, byte_valid: v, stop_seen: s};
      r.n         = l.n + 1'b1;
    end
    return r;
  endfunction

  // push out whatever a pending sequence stands for
  function automatic res_list_t flush_pend(res_list_t l, mode_t m, logic [7:0] acc,
                                           logic [CntW-1:0] dc);
    res_list_t r;
    r = l;
    unique case (m)
      MODE_BACKSLASH: r = emit(r, CH_BSL, 1'b1, 1'b0);
      MODE_OCTAL:     r = emit(r, (dc != '0) ? acc : CH_NUL, 1'b1, 1'b0);
      MODE_HEX: begin
        if (dc != '0) begin
          r = emit(r, acc, 1'b1, 1'b0);
        end else begin
          r = emit(r, CH_BSL, 1'b1, 1'b0);
          r = emit(r, CH_LOW_X, 1'b1, 1'b0);
        end
      end
      default: r = l;
    endcase
    return r;
  endfunction

  // hex digit value of a character
  function automatic hex_dig_t hex_digit(logic [7:0] b);
    hex_dig_t h;
    h.ok  = 1'b0;
    h.val = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      h.ok  = 1'b1;
      h.val = 4'(b - 8'h30);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      h.ok  = 1'b1;
      h.val = 4'(b - 8'h57);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      h.ok  = 1'b1;
      h.val = 4'(b - 8'h37);
    end
    return h;
  endfunction

endpackage

// File: hdl/backslash_escape_decoder.sv
// top level: streaming backslash escape decoder with a result buffer
`timescale 1ns / 1ps

// Echo-style backslash escape decoder.
// Input channel (in_*): one text byte per word in in_tdata, in_tlast on the
// final byte of a message. Output channel (out_*): decoded bytes in
// out_tdata, out_tuser = {stop_seen, byte_valid}, out_tlast on the last
// result word caused by an input word. An input word may cause zero to three
// result words; a word causing none leaves no trace on the output.
// Configuration: cfg_data[0] set to 1 turns escape decoding on, 0 passes
// bytes straight through. Write it only while the block is idle.
// The first result of a word is registered and shown the cycle after acceptance.
// Throughput: one input word per cycle while each causes at most one result
// and the receiver keeps out_tready high; a word with more results holds the
// result buffer until all have left, since the buffer drains one word per cycle
// while out_tready is high. The decode itself is a single pass of logic between
// the mode registers and the result buffer. A new input word is taken in the
// same cycle the buffer's last word leaves. When the receiver stalls, the buffer
// holds and in_tready stays low while it holds results. Reset clears the mode, the buffer and turns escapes off.
module backslash_escape_decoder (
  input  logic                 clk,
  input  logic                 rst_n,
  // input stream
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [7:0]           in_tdata,   // [7:0] text_byte
  input  logic                 in_tlast,   // end_of_message
  // result stream
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [7:0]           out_tdata,  // [7:0] out_byte
  output logic [1:0]           out_tuser,  // [0] byte_valid, [1] stop_seen
  output logic                 out_tlast,  // last_in_run
  // configuration write
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [0:0]           cfg_data    // [0] escapes_enabled
);
  import bed_pkg::*;

  logic            esc_en_r;
  mode_t           mode_r, mode_nxt;
  logic [7:0]      acc_r, acc_nxt;
  logic [CntW-1:0] dc_r, dc_nxt;
  res_list_t       dec_res;
  res_list_t       buf_r;
  logic [CntW-1:0] cnt_r;
  logic [CntW-1:0] rd_r;
  logic            in_take;
  logic            out_take;
  logic            out_end;

  // configuration register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_en_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      esc_en_r <= cfg_data[0];
    end
  end

  // handshakes
  assign out_tvalid = (cnt_r != '0);
  assign out_end    = (rd_r == cnt_r - 1'b1);
  assign out_take   = out_tvalid && out_tready;
  assign in_tready  = (cnt_r == '0) || (out_tready && out_end);
  assign in_take    = in_tvalid && in_tready;

  // decode one byte against the current mode
  always_comb begin : decode
    mode_t      m;
    logic [7:0] acc;
    logic [CntW-1:0] dc;
    logic [7:0] b;
    hex_dig_t   h;
    res_list_t  r;
    m   = mode_r;
    acc = acc_r;
    dc  = dc_r;
    b   = in_tdata;
    h   = hex_digit(b);
    r   = '0;

    if (esc_en_r) begin
      unique case (m)
        MODE_BACKSLASH: begin
          m = MODE_NORMAL;
          case (b)
            CH_BSL:   r = emit(r, CH_BSL, 1'b1, 1'b0);
            CH_LOW_A: r = emit(r, CH_BEL, 1'b1, 1'b0);
            CH_LOW_B: r = emit(r, CH_BS,  1'b1, 1'b0);
            CH_LOW_E: r = emit(r, CH_ESC, 1'b1, 1'b0);
            CH_LOW_F: r = emit(r, CH_FF,  1'b1, 1'b0);
            CH_LOW_N: r = emit(r, CH_LF,  1'b1, 1'b0);
            CH_LOW_R: r = emit(r, CH_CR,  1'b1, 1'b0);
            CH_LOW_T: r = emit(r, CH_HT,  1'b1, 1'b0);
            CH_LOW_V: r = emit(r, CH_VT,  1'b1, 1'b0);
            CH_LOW_C: begin
              r = emit(r, CH_NUL, 1'b0, 1'b1);
              m = MODE_STOPPED;
            end
            CH_ZERO: begin
              m   = MODE_OCTAL;
              acc = '0;
              dc  = '0;
            end
            CH_LOW_X: begin
              m   = MODE_HEX;
              acc = '0;
              dc  = '0;
            end
            default: begin
              r = emit(r, CH_BSL, 1'b1, 1'b0);
              r = emit(r, b, 1'b1, 1'b0);
            end
          endcase
        end
        MODE_OCTAL: begin
          if (b[7:3] == CH_ZERO[7:3] && dc < OctDigits) begin
            acc = {acc[4:0], b[2:0]};
            dc  = dc + 1'b1;
            if (dc >= OctDigits) begin
              r   = emit(r, acc, 1'b1, 1'b0);
              m   = MODE_NORMAL;
              acc = '0;
              dc  = '0;
            end
          end else begin
            r   = flush_pend(r, m, acc, dc);
            acc = '0;
            dc  = '0;
            if (b == CH_BSL) m = MODE_BACKSLASH;
            else begin
              m = MODE_NORMAL;
              r = emit(r, b, 1'b1, 1'b0);
            end
          end
        end
        MODE_HEX: begin
          if (h.ok && dc < HexDigits) begin
            acc = {acc[3:0], h.val};
            dc  = dc + 1'b1;
            if (dc >= HexDigits) begin
              r   = emit(r, acc, 1'b1, 1'b0);
              m   = MODE_NORMAL;
              acc = '0;
              dc  = '0;
            end
          end else begin
            r   = flush_pend(r, m, acc, dc);
            acc = '0;
            dc  = '0;
            if (b == CH_BSL) m = MODE_BACKSLASH;
            else begin
              m = MODE_NORMAL;
              r = emit(r, b, 1'b1, 1'b0);
            end
          end
        end
        MODE_STOPPED: begin
          m = MODE_STOPPED;
        end
        default: begin
          if (b == CH_BSL) m = MODE_BACKSLASH;
          else begin
            m = MODE_NORMAL;
            r = emit(r, b, 1'b1, 1'b0);
          end
        end
      endcase
    end else if (m != MODE_STOPPED) begin
      // pass-through, after flushing any pending sequence
      r   = flush_pend(r, m, acc, dc);
      m   = MODE_NORMAL;
      acc = '0;
      dc  = '0;
      r   = emit(r, b, 1'b1, 1'b0);
    end

    // end of message: flush and return to reset values
    if (in_tlast) begin
      r   = flush_pend(r, m, acc, dc);
      m   = MODE_NORMAL;
      acc = '0;
      dc  = '0;
    end

    mode_nxt = m;
    acc_nxt  = acc;
    dc_nxt   = dc;
    dec_res  = r;
  end

  // mode registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_NORMAL;
      acc_r  <= '0;
      dc_r   <= '0;
    end else if (in_take) begin
      mode_r <= mode_nxt;
      acc_r  <= acc_nxt;
      dc_r   <= dc_nxt;
    end
  end

  // result buffer: loaded per input word, drained one word per cycle while out_tready is high
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      rd_r  <= '0;
    end else if (in_take) begin
      cnt_r <= dec_res.n;
      rd_r  <= '0;
    end else if (out_take) begin
      if (out_end) begin
        cnt_r <= '0;
        rd_r  <= '0;
      end else begin
        rd_r <= rd_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      buf_r <= dec_res;
    end
  end

  // output word
  assign out_tdata = buf_r.item[rd_r].out_byte;
  assign out_tuser = {buf_r.item[rd_r].stop_seen, buf_r.item[rd_r].byte_valid};
  assign out_tlast = out_end;

endmodule
